// ===== rtl/tddt_pkg.sv =====
package tddt_pkg;

  // Field widths
  localparam int unsigned SampleW = 22;
  localparam int unsigned TickW   = 32;
  localparam int unsigned TimeW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = SampleW;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDebounce  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWindow    = 2'd2;

  // Configuration reset values
  localparam logic [SampleW-1:0] ThresholdRst = '0;
  localparam logic [TimeW-1:0]   DebounceRst  = 16'd5;
  localparam logic [TimeW-1:0]   WindowRst    = 16'd30;

  // Reported gesture codes
  typedef enum logic [1:0] {
    GestNone   = 2'd0,
    GestSingle = 2'd1,
    GestDouble = 2'd2
  } gesture_e;

endpackage

// ===== rtl/touch_debounce_double_tap.sv =====
// Timing: a poll is captured in the input register, then its result in the result register.
// Throughput: one poll per cycle while the result channel is not stalled; the state update is a
// single pass through the threshold compare and two 32-bit elapsed-time subtractions between the two registers.
// Reset: rst_ni is asynchronous, active low; it empties both stages, clears the
// debounce and gesture state and loads the configuration defaults (threshold 0,
// debounce 5 ticks, window 30 ticks).
module touch_debounce_double_tap
  import tddt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // Poll input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SampleW-1:0] sample_i,
  input  logic               read_failed_i,
  input  logic [TickW-1:0]   now_tick_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         gesture_o,
  output logic               touched_o
);

  // Configuration registers
  logic [SampleW-1:0] threshold_q;
  logic [TimeW-1:0]   debounce_q;
  logic [TimeW-1:0]   window_q;

  // Input stage
  logic               s1_valid_q;
  logic [SampleW-1:0] s1_sample_q;
  logic               s1_failed_q;
  logic [TickW-1:0]   s1_now_q;
  logic               s1_advance;

  // Detector state
  logic               raw_last_q, raw_last_d;
  logic [TickW-1:0]   change_tick_q, change_tick_d;
  logic               debounced_q, debounced_d;
  logic [TickW-1:0]   release_tick_q, release_tick_d;
  logic               awaiting_q, awaiting_d;

  // Result stage
  logic               out_valid_q;
  gesture_e           gesture_q, gesture_d;
  logic               touched_q;

  // Combinational evaluation
  logic               raw;
  logic [TickW-1:0]   stable_time;
  logic [TickW-1:0]   since_release;
  logic               flip;
  logic               release_now;
  logic               armed;

  // Move the input stage on when the result register is free or being emptied
  assign s1_advance  = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_advance;
  assign out_valid_o = out_valid_q;
  assign gesture_o   = gesture_q;
  assign touched_o   = touched_q;

  // Load configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= ThresholdRst;
      debounce_q  <= DebounceRst;
      window_q    <= WindowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgThreshold: threshold_q <= cfg_data_i;
        CfgDebounce:  debounce_q  <= cfg_data_i[TimeW-1:0];
        CfgWindow:    window_q    <= cfg_data_i[TimeW-1:0];
        default: ;
      endcase
    end
  end

  // Hold the input stage valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  // Capture the poll on transfer
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_sample_q <= sample_i;
      s1_failed_q <= read_failed_i;
      s1_now_q    <= now_tick_i;
    end
  end

  // Debounce and gesture evaluation
  always_comb begin
    raw          = !s1_failed_q && (s1_sample_q < threshold_q);
    raw_last_d   = raw;
    // A fresh raw change restarts the stability timer at this tick
    change_tick_d = (raw != raw_last_q) ? s1_now_q : change_tick_q;
    stable_time   = (raw != raw_last_q) ? '0 : (s1_now_q - change_tick_q);
    flip          = (stable_time >= {{(TickW-TimeW){1'b0}}, debounce_q})
                    && (raw != debounced_q);
    release_now   = flip && !raw;
    debounced_d   = flip ? raw : debounced_q;
    release_tick_d = release_now ? s1_now_q : release_tick_q;
    since_release  = release_now ? '0 : (s1_now_q - release_tick_q);

    gesture_d = GestNone;
    armed     = awaiting_q;
    if (release_now) begin
      if (awaiting_q) begin
        armed     = 1'b0;
        gesture_d = GestDouble;
      end else begin
        armed = 1'b1;
      end
    end

    // Report a single touch once the window after release runs out
    awaiting_d = armed;
    if (armed && !debounced_d
        && (since_release >= {{(TickW-TimeW){1'b0}}, window_q})) begin
      awaiting_d = 1'b0;
      gesture_d  = GestSingle;
    end
  end

  // Update detector state once per evaluated poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_last_q     <= 1'b0;
      change_tick_q  <= '0;
      debounced_q    <= 1'b0;
      release_tick_q <= '0;
      awaiting_q     <= 1'b0;
    end else if (s1_advance) begin
      raw_last_q     <= raw_last_d;
      change_tick_q  <= change_tick_d;
      debounced_q    <= debounced_d;
      release_tick_q <= release_tick_d;
      awaiting_q     <= awaiting_d;
    end
  end

  // Hold the result valid flag until transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      gesture_q <= gesture_d;
      touched_q <= debounced_d;
    end
  end

`ifndef SYNTHESIS
  // A reported gesture always ends with the pad released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (gesture_q == GestSingle || gesture_q == GestDouble) |-> !touched_o)
    else $error("gesture reported while still touched");

  // Any gesture closes the wait for a second touch
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance && (gesture_d != GestNone) |=> !awaiting_q)
    else $error("wait still armed after a gesture");

  // Input is only refused while a full result stage is stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i && s1_valid_q)
    else $error("input refused without output back-pressure");
`endif

endmodule
